// ===== rtl/hds_pkg.sv =====
// Shared types and constants for the five-point heat diffusion stencil.
// Self-contained: no dependencies. Used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

  // Grid limits (line buffer depth and row count).
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  localparam int COL_W  = $clog2(MAX_COLS);  // line buffer address
  localparam int ROW_W  = $clog2(MAX_ROWS);  // row counter
  localparam int DIM_W  = 7;                 // grid size registers
  localparam int IDX_W  = 6;                 // cell_row / cell_col fields
  localparam int TEMP_W = 32;                // Q16.16 temperature
  localparam int COEF_W = 16;                // Q0.16 coefficient
  localparam int DIFF_W = TEMP_W + 2;        // up - 2*centre + down
  localparam int PROD_W = DIFF_W + COEF_W + 1;
  localparam int TERM_W = PROD_W - COEF_W;   // product after >>> 16
  localparam int SUM_W  = TERM_W + 1;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);

  localparam logic [DIM_W-1:0] RESET_COLS = DIM_W'(50);
  localparam logic [DIM_W-1:0] RESET_ROWS = DIM_W'(50);
  localparam logic [COEF_W-1:0] RESET_COEF = COEF_W'(655);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 2'd0,
    REG_GRID_ROWS = 2'd1,
    REG_COEF_X    = 2'd2,
    REG_COEF_Y    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     first_of_frame;
  } cell_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] new_temperature;
    logic [IDX_W-1:0]         cell_row;
    logic [IDX_W-1:0]         cell_col;
    logic                     last_of_frame;
  } result_t;

  // Load strobes for the three pipeline registers.
  typedef struct packed {
    logic a_load;
    logic b_load;
    logic c_load;
  } pipe_ctrl_t;

  // Line buffer stage: item plus its column neighbours read from the stores.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic signed [TEMP_W-1:0] top;
    logic signed [TEMP_W-1:0] mid;
    logic [COL_W-1:0]         col;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     emit;
    logic                     last;
  } stage_a_t;

  // Window stage: second differences of the centre cell.
  typedef struct packed {
    logic signed [TEMP_W-1:0] centre;
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     emit;
    logic                     last;
  } stage_b_t;

endpackage

`default_nettype wire

// ===== rtl/hds_line_buf.sv =====
// Position counters and the two row line buffers of the stencil.
// Depends on hds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hds_line_buf
  import hds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pipe_ctrl_t       ctrl,
  input  wire cell_t            cell_data,
  input  wire logic [DIM_W-1:0] cols,
  input  wire logic [DIM_W-1:0] rows,
  output stage_a_t              stage_a
);

  logic signed [TEMP_W-1:0] upper_row_store [MAX_COLS];
  logic signed [TEMP_W-1:0] middle_row_store [MAX_COLS];

  logic [ROW_W-1:0] row_counter;
  logic [COL_W-1:0] col_counter;

  logic [DIM_W-1:0] r_cur, c_cur, r_inc, c_inc;
  logic [COL_W-1:0] addr;
  logic             bypass;

  always_comb begin
    r_cur = cell_data.first_of_frame ? '0 : DIM_W'(row_counter);
    c_cur = cell_data.first_of_frame ? '0 : DIM_W'(col_counter);
    if (c_cur >= cols) begin
      c_cur = '0;
      r_cur = r_cur + DIM_W'(1);
    end
    if (r_cur >= rows) r_cur = '0;
    r_inc = r_cur;
    c_inc = c_cur + DIM_W'(1);
    if (c_inc >= cols) begin
      c_inc = '0;
      r_inc = r_cur + DIM_W'(1);
      if (r_inc >= rows) r_inc = '0;
    end
  end

  assign addr = c_cur[COL_W-1:0];
  // forward the upper row write that lands on the address read this cycle
  assign bypass = ctrl.b_load && (stage_a.col == addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
    end else if (ctrl.a_load) begin
      row_counter <= r_inc[ROW_W-1:0];
      col_counter <= c_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.b_load) upper_row_store[stage_a.col] <= stage_a.mid;
    if (ctrl.a_load) begin
      middle_row_store[addr] <= cell_data.temperature;
      stage_a.mid            <= middle_row_store[addr];
      stage_a.top            <= bypass ? stage_a.mid : upper_row_store[addr];
      stage_a.temperature    <= cell_data.temperature;
      stage_a.col            <= addr;
      stage_a.out_row        <= IDX_W'(r_cur - DIM_W'(1));
      stage_a.out_col        <= IDX_W'(c_cur - DIM_W'(1));
      stage_a.emit           <= (r_cur >= DIM_W'(2)) && (c_cur >= DIM_W'(2));
      stage_a.last           <= (r_cur == rows - DIM_W'(1)) && (c_cur == cols - DIM_W'(1));
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hds_window.sv =====
// Neighbourhood window and second-difference stage of the stencil.
// Depends on hds_pkg; fed by hds_line_buf.
`timescale 1ns / 1ps
`default_nettype none

module hds_window
  import hds_pkg::*;
(
  input  wire logic     clk,
  input  wire pipe_ctrl_t ctrl,
  input  wire stage_a_t stage_a,
  output stage_b_t      stage_b
);

  // up: row r-2, centre/left: row r-1, down: row r; column c-1, left at c-2
  logic signed [TEMP_W-1:0] w_up, w_centre, w_left, w_down;
  logic signed [DIFF_W-1:0] twice_centre;

  assign twice_centre = DIFF_W'(w_centre) <<< 1;

  always_ff @(posedge clk) begin
    if (ctrl.b_load) begin
      stage_b.diff_x  <= DIFF_W'(w_up) - twice_centre + DIFF_W'(w_down);
      stage_b.diff_y  <= DIFF_W'(w_left) - twice_centre + DIFF_W'(stage_a.mid);
      stage_b.centre  <= w_centre;
      stage_b.out_row <= stage_a.out_row;
      stage_b.out_col <= stage_a.out_col;
      stage_b.emit    <= stage_a.emit;
      stage_b.last    <= stage_a.last;
      // advance the window by one column
      w_up     <= stage_a.top;
      w_left   <= w_centre;
      w_centre <= stage_a.mid;
      w_down   <= stage_a.temperature;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hds_update.sv =====
// Coefficient multiply, sum and saturation into the result register.
// Depends on hds_pkg; fed by hds_window.
`timescale 1ns / 1ps
`default_nettype none

module hds_update
  import hds_pkg::*;
(
  input  wire logic              clk,
  input  wire pipe_ctrl_t        ctrl,
  input  wire stage_b_t          stage_b,
  input  wire logic [COEF_W-1:0] coef_x,
  input  wire logic [COEF_W-1:0] coef_y,
  output result_t                result
);

  logic signed [COEF_W:0]   cx, cy;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [TERM_W-1:0] term_x, term_y;
  logic signed [SUM_W-1:0]  sum;
  logic signed [TEMP_W-1:0] sat;

  assign cx     = {1'b0, coef_x};
  assign cy     = {1'b0, coef_y};
  assign prod_x = PROD_W'(cx) * PROD_W'(stage_b.diff_x);
  assign prod_y = PROD_W'(cy) * PROD_W'(stage_b.diff_y);
  // arithmetic shift: drop the fraction, rounding toward minus infinity
  assign term_x = prod_x[PROD_W-1:COEF_W];
  assign term_y = prod_y[PROD_W-1:COEF_W];
  assign sum    = SUM_W'(stage_b.centre) + SUM_W'(term_x) + SUM_W'(term_y);

  always_comb begin
    if (sum[SUM_W-1:TEMP_W-1] == '0 || sum[SUM_W-1:TEMP_W-1] == '1) begin
      sat = sum[TEMP_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(TEMP_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(TEMP_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.c_load) begin
      result.new_temperature <= sat;
      result.cell_row        <= stage_b.out_row;
      result.cell_col        <= stage_b.out_col;
      result.last_of_frame   <= stage_b.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/heat_diffusion_stencil_step.sv =====
// One explicit-Euler step of the 2-D heat equation over a raster cell stream.
// An accepted item is registered in stage A, then stage B, then the output
// register; one item per cycle sustained, each line buffer taking one read
// and one write per cycle. A held result stalls cells only once it backs up.
// Reset (synchronous, rst high): counters to (0,0), pipeline empty, size 50x50,
// both coefficients 655; line buffers and window are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module heat_diffusion_stencil_step
  import hds_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // cell stream
  input  wire logic                 cell_valid,
  output logic                      cell_stall,
  input  wire cell_t                cell_data,
  // result stream
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  // configuration writes
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [DIM_W-1:0]  grid_cols, grid_rows;
  logic [COEF_W-1:0] coef_x, coef_y;
  logic [DIM_W-1:0]  cols, rows;

  // Pipeline occupancy: A = line buffer read, B = window, C = result.
  logic       va, vb, vc;
  logic       ready_a, ready_b, ready_c;
  logic       a_leave, b_leave, accept;
  pipe_ctrl_t ctrl;
  stage_a_t   stage_a;
  stage_b_t   stage_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= RESET_COLS;
      grid_rows <= RESET_ROWS;
      coef_x    <= RESET_COEF;
      coef_y    <= RESET_COEF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_COLS: grid_cols <= cfg_data[DIM_W-1:0];
        REG_GRID_ROWS: grid_rows <= cfg_data[DIM_W-1:0];
        REG_COEF_X:    coef_x    <= cfg_data[COEF_W-1:0];
        REG_COEF_Y:    coef_y    <= cfg_data[COEF_W-1:0];
        default:       ;
      endcase
    end
  end

  // Clamp the grid size to at least DIM_MIN and to what the line buffers hold.
  always_comb begin
    cols = grid_cols;
    if (grid_cols < DIM_MIN) cols = DIM_MIN;
    else if (grid_cols > DIM_W'(MAX_COLS)) cols = DIM_W'(MAX_COLS);
    rows = grid_rows;
    if (grid_rows < DIM_MIN) rows = DIM_MIN;
    else if (grid_rows > DIM_W'(MAX_ROWS)) rows = DIM_W'(MAX_ROWS);
  end

  // Each stage moves on when the next one is free or moving; an item that
  // yields no result leaves stage B without touching the result register,
  // so bubbles close up and cells keep flowing while a result waits.
  assign ready_c = !vc || !result_stall;
  assign b_leave = vb && (!stage_b.emit || ready_c);
  assign ready_b = !vb || b_leave;
  assign a_leave = va && ready_b;
  assign ready_a = !va || a_leave;
  assign accept  = cell_valid && ready_a;

  assign cell_stall  = !ready_a;
  assign ctrl.a_load = accept;
  assign ctrl.b_load = a_leave;
  assign ctrl.c_load = b_leave && stage_b.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (accept) va <= 1'b1;
      else if (a_leave) va <= 1'b0;
      if (a_leave) vb <= 1'b1;
      else if (b_leave) vb <= 1'b0;
      if (ctrl.c_load) vc <= 1'b1;
      else if (!result_stall) vc <= 1'b0;
    end
  end

  assign result_valid = vc;

  hds_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cell_data (cell_data),
    .cols      (cols),
    .rows      (rows),
    .stage_a   (stage_a)
  );

  hds_window u_window (
    .clk     (clk),
    .ctrl    (ctrl),
    .stage_a (stage_a),
    .stage_b (stage_b)
  );

  hds_update u_update (
    .clk     (clk),
    .ctrl    (ctrl),
    .stage_b (stage_b),
    .coef_x  (coef_x),
    .coef_y  (coef_y),
    .result  (result)
  );

  // An empty front stage always takes a cell.
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !va |-> !cell_stall)
    else $error("cell stalled with line buffer stage empty");

  // An item leaving stage A lands in stage B.
  a_to_b: assert property (@(posedge clk) disable iff (rst)
    a_leave |=> vb)
    else $error("item lost between line buffer and window");

  // Only interior cells come out: no result names row 0 or column 0.
  interior_only: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.cell_row != '0) && (result.cell_col != '0))
    else $error("boundary cell emitted");

endmodule

`default_nettype wire

// ===== verif/tb_heat_diffusion_stencil_step.sv =====
// Self-checking testbench for heat_diffusion_stencil_step: a directed table and then
// random raster frames, each result checked against a stencil predictor kept in the bench.
// Depends on rtl/hds_pkg.sv and the other sources under rtl/.
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_step;
  import hds_pkg::*;

  // Run shape
  localparam int RANDOM_CELLS = 600;
  localparam int PIPE_SETTLE  = 4;          // extra wait once every awaited result is home
  localparam int REPORT_CAP   = 20;
  localparam int WIDE_PHASE   = 2;          // 64 columns by 3 rows
  localparam int TALL_PHASE   = 5;          // 3 columns by 64 rows
  localparam longint TEMP_MAX = 64'sd2147483647;
  localparam longint TEMP_MIN = -64'sd2147483648;

  // Directed settings, applied when the table moves from one to the next
  localparam logic [1:0] DIR_FLAT     = 2'd0; // 3x3 from clamped sizes, both coefficients zero
  localparam logic [1:0] DIR_SATURATE = 2'd1; // 4x4, coefficients at and above one half
  localparam logic [1:0] DIR_SHRINK   = 2'd2; // drop to 3 columns with the counter at column 3

  // Ways of running a random phase
  localparam int RUN_FRAMES = 0;            // whole frames, each opened by first_of_frame
  localparam int RUN_ONWARD = 1;            // carry on from wherever the counters stand
  localparam int RUN_NOISE  = 2;            // first_of_frame dropped in at random

  // Flavours of temperature data
  localparam int DATA_RANDOM  = 0;
  localparam int DATA_SMOOTH  = 1;
  localparam int DATA_EXTREME = 2;
  localparam int DATA_MIXED   = 3;

  localparam result_t NO_RESULT = '0;

  typedef struct packed {
    logic [1:0]               setting;
    logic signed [TEMP_W-1:0] temperature;
    logic                     first_of_frame;
    logic                     known;
    result_t                  want;
  } directed_cell_t;

  localparam int DIRECTED_LEN = 22;

  // Directed table. Frame one runs with both coefficients at zero, so the single
  // interior cell must come back unchanged and is typed in; the rest go through
  // the predictor. Frame two starts without first_of_frame (wrap at end of frame),
  // then the grid narrows while the column counter sits beyond the new width.
  directed_cell_t directed_cells [DIRECTED_LEN] = '{
    '{DIR_FLAT,     32'sh8000_0000, 1'b1, 1'b0, NO_RESULT},
    '{DIR_FLAT,     32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{DIR_FLAT,     32'sh0000_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_FLAT,     32'shFFFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{DIR_FLAT,     32'sh1234_5678, 1'b0, 1'b0, NO_RESULT},
    '{DIR_FLAT,     32'sh0000_0001, 1'b0, 1'b0, NO_RESULT},
    '{DIR_FLAT,     32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{DIR_FLAT,     32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_FLAT,     32'shEDCB_A987, 1'b0, 1'b1, '{32'sh1234_5678, 6'd1, 6'd1, 1'b1}},
    '{DIR_SATURATE, 32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SATURATE, 32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SATURATE, 32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SATURATE, 32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SATURATE, 32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SATURATE, 32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SATURATE, 32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SHRINK,   32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SHRINK,   32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SHRINK,   32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SHRINK,   32'sh0000_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SHRINK,   32'sh0001_0000, 1'b0, 1'b0, NO_RESULT},
    '{DIR_SHRINK,   32'shFFFF_FFFF, 1'b0, 1'b0, NO_RESULT}
  };

  // DUT connections
  logic                 clk;
  logic                 rst;
  logic                 cell_valid;
  logic                 cell_stall;
  cell_t                cell_data;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Bench copy of the registers and of the stencil state
  logic [DIM_W-1:0]         grid_cols_q;
  logic [DIM_W-1:0]         grid_rows_q;
  logic [COEF_W-1:0]        coef_x_q;
  logic [COEF_W-1:0]        coef_y_q;
  logic signed [TEMP_W-1:0] upper_line  [MAX_COLS];
  logic signed [TEMP_W-1:0] middle_line [MAX_COLS];
  logic signed [TEMP_W-1:0] window      [6];
  int unsigned              row_pos;
  int unsigned              col_pos;

  result_t awaited_results [$];
  int      failures;
  int      cells_sent;
  int      results_checked;
  int      saturated_seen;
  int      settings_used;
  int      burst_left;

  heat_diffusion_stencil_step dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_data    (cell_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("heat_diffusion_stencil_step regression: fail");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the stencil by one cell; return 1 and fill upd when an interior cell is due.
  function automatic bit stencil_advance(input cell_t item, output result_t upd);
    int unsigned              cols;
    int unsigned              rows;
    int unsigned              r;
    int unsigned              c;
    logic signed [TEMP_W-1:0] top;
    logic signed [TEMP_W-1:0] mid;
    longint                   centre;
    longint                   lap_x;
    longint                   lap_y;
    longint                   total;
    bit                       due;

    cols = clamp_dim(grid_cols_q, MAX_COLS);
    rows = clamp_dim(grid_rows_q, MAX_ROWS);
    if (item.first_of_frame) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    // a narrowed grid pushes the counter onto the next row, a shorter one back to row 0
    if (c >= cols) begin
      c = 0;
      r++;
    end
    if (r >= rows) r = 0;

    top = upper_line[c];
    mid = middle_line[c];
    due = (r >= 2) && (c >= 2);
    upd = NO_RESULT;
    if (due) begin
      centre = window[2];
      lap_x  = longint'(window[0]) - 2 * centre + longint'(window[4]);
      lap_y  = longint'(window[3]) - 2 * centre + longint'(mid);
      total  = centre + ((longint'(coef_x_q) * lap_x) >>> 16)
                      + ((longint'(coef_y_q) * lap_y) >>> 16);
      if (total > TEMP_MAX || total < TEMP_MIN) saturated_seen++;
      if (total > TEMP_MAX) total = TEMP_MAX;
      if (total < TEMP_MIN) total = TEMP_MIN;
      upd.new_temperature = total[TEMP_W-1:0];
      upd.cell_row        = IDX_W'(r - 1);
      upd.cell_col        = IDX_W'(c - 1);
      upd.last_of_frame   = (r == rows - 1) && (c == cols - 1);
    end

    // shift the window one column and roll the line stores
    window[1] = window[0];
    window[0] = top;
    window[3] = window[2];
    window[2] = mid;
    window[5] = window[4];
    window[4] = item.temperature;
    upper_line[c]  = mid;
    middle_line[c] = item.temperature;

    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    row_pos = r;
    col_pos = c;
    return due;
  endfunction

  // Write one register and mirror it; cfg_write stays high for back-to-back writes.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_GRID_COLS: grid_cols_q = data[DIM_W-1:0];
      REG_GRID_ROWS: grid_rows_q = data[DIM_W-1:0];
      REG_COEF_X:    coef_x_q    = data;
      REG_COEF_Y:    coef_y_q    = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Offer one item, honouring bursts and gaps, and predict once it is taken.
  task automatic send_cell(input cell_t item, input bit known, input result_t want);
    result_t upd;
    int      gap;

    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        cell_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cell_valid <= 1'b1;
    cell_data  <= item;
    do @(posedge clk); while (cell_stall);
    cells_sent++;
    if (stencil_advance(item, upd) || known) awaited_results.push_back(known ? want : upd);
  endtask

  // Drop valid and hold off until every result is home and the pipeline is empty.
  task automatic settle_block();
    @(negedge clk);
    cell_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic apply_directed_setting(input logic [1:0] setting);
    case (setting)
      DIR_FLAT: begin
        // sizes below the minimum clamp to a 3x3 grid
        write_reg(REG_GRID_COLS, 16'd0);
        write_reg(REG_GRID_ROWS, 16'd2);
        write_reg(REG_COEF_X, 16'd0);
        write_reg(REG_COEF_Y, 16'd0);
      end
      DIR_SATURATE: begin
        write_reg(REG_GRID_COLS, 16'd4);
        write_reg(REG_GRID_ROWS, 16'd4);
        write_reg(REG_COEF_X, 16'hFFFF);
        write_reg(REG_COEF_Y, 16'h8000);
      end
      default: write_reg(REG_GRID_COLS, 16'd3);
    endcase
    end_writes();
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'(RESET_COEF);
      4:       return 16'($urandom_range(0, 16'h8000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Size word with junk above the 7-bit field; only the low bits count.
  function automatic logic [CFG_W-1:0] size_word(input logic [DIM_W-1:0] v);
    logic [CFG_W-1:0] w;
    w = 16'($urandom);
    w[DIM_W-1:0] = v;
    return w;
  endfunction

  function automatic logic [TEMP_W-1:0] pick_temperature(input int style);
    int kind;
    kind = (style == DATA_MIXED) ? $urandom_range(DATA_RANDOM, DATA_EXTREME) : style;
    case (kind)
      DATA_SMOOTH: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
      DATA_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'($urandom);
        endcase
      end
      default: return 32'($urandom);
    endcase
  endfunction

  // One random phase: new setting while idle, then a stream of cells.
  task automatic run_random_phase(input int phase_no);
    logic [DIM_W-1:0] raw_cols;
    logic [DIM_W-1:0] raw_rows;
    int unsigned      old_cols;
    int unsigned      cols;
    int unsigned      frame_len;
    int unsigned      count;
    int               mode;
    int               style;
    int               sel;
    bit               force_first;
    cell_t            item;

    old_cols = clamp_dim(grid_cols_q, MAX_COLS);
    if (phase_no == WIDE_PHASE) begin
      raw_cols = DIM_W'($urandom_range(64, 127));
      raw_rows = DIM_W'($urandom_range(0, 3));
    end else if (phase_no == TALL_PHASE) begin
      raw_cols = DIM_W'($urandom_range(0, 3));
      raw_rows = DIM_W'($urandom_range(64, 127));
    end else begin
      raw_cols = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2))
                                             : DIM_W'($urandom_range(3, 7));
      raw_rows = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2))
                                             : DIM_W'($urandom_range(3, 6));
    end
    write_reg(REG_GRID_COLS, size_word(raw_cols));
    write_reg(REG_GRID_ROWS, size_word(raw_rows));
    if (phase_no == 0 || $urandom_range(0, 1)) write_reg(REG_COEF_X, pick_coef());
    if (phase_no == 0 || $urandom_range(0, 1)) write_reg(REG_COEF_Y, pick_coef());
    end_writes();

    cols      = clamp_dim(grid_cols_q, MAX_COLS);
    frame_len = cols * clamp_dim(grid_rows_q, MAX_ROWS);
    // columns beyond the old width hold nothing yet: open a fresh frame before
    // a wider grid can read them
    force_first = (cols > old_cols) && (row_pos != 0 || col_pos != 0);

    sel = $urandom_range(0, 9);
    if (phase_no == WIDE_PHASE || phase_no == TALL_PHASE) mode = RUN_FRAMES;
    else mode = (sel < 7) ? RUN_FRAMES : (sel < 9) ? RUN_ONWARD : RUN_NOISE;
    case (mode)
      RUN_FRAMES: begin
        if (phase_no == WIDE_PHASE || phase_no == TALL_PHASE) count = frame_len;
        else count = frame_len * $urandom_range(1, 2);
      end
      RUN_ONWARD: count = $urandom_range(4, 2 * frame_len);
      default:    count = $urandom_range(5, 30);
    endcase
    style = $urandom_range(DATA_RANDOM, DATA_MIXED);

    for (int unsigned k = 0; k < count; k++) begin
      item.temperature = pick_temperature(style);
      case (mode)
        RUN_FRAMES: item.first_of_frame = (k % frame_len == 0);
        RUN_ONWARD: item.first_of_frame = 1'b0;
        default:    item.first_of_frame = ($urandom_range(0, 9) == 0);
      endcase
      if (k == 0 && force_first) item.first_of_frame = 1'b1;
      send_cell(item, 1'b0, NO_RESULT);
    end
    settle_block();
  endtask

  // Receiver: stall on a pattern chosen at random for each random span, including
  // stretches with no stall at all.
  initial begin : result_sink
    int mode;
    int span;
    int tick;

    result_stall = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= $urandom_range(0, 1);
          default: result_stall <= (tick % 4 != 0);
        endcase
      end
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;

    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, got %p", $time, result);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (result.new_temperature !== want.new_temperature) begin
          failures++;
          if (failures <= REPORT_CAP)
            $display("%0t: new_temperature expected %h, got %h", $time,
                     want.new_temperature, result.new_temperature);
        end
        if (result.cell_row !== want.cell_row) begin
          failures++;
          if (failures <= REPORT_CAP)
            $display("%0t: cell_row expected %0d, got %0d", $time, want.cell_row,
                     result.cell_row);
        end
        if (result.cell_col !== want.cell_col) begin
          failures++;
          if (failures <= REPORT_CAP)
            $display("%0t: cell_col expected %0d, got %0d", $time, want.cell_col,
                     result.cell_col);
        end
        if (result.last_of_frame !== want.last_of_frame) begin
          failures++;
          if (failures <= REPORT_CAP)
            $display("%0t: last_of_frame expected %b, got %b", $time, want.last_of_frame,
                     result.last_of_frame);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin
    int         phase_no;
    logic [1:0] setting;

    rst         = 1'b1;
    cell_valid  = 1'b0;
    cell_data   = '0;
    cfg_write   = 1'b0;
    cfg_index   = REG_GRID_COLS;
    cfg_data    = '0;
    grid_cols_q = RESET_COLS;
    grid_rows_q = RESET_ROWS;
    coef_x_q    = RESET_COEF;
    coef_y_q    = RESET_COEF;
    row_pos     = 0;
    col_pos     = 0;
    for (int k = 0; k < MAX_COLS; k++) begin
      upper_line[k]  = '0;
      middle_line[k] = '0;
    end
    for (int k = 0; k < 6; k++) window[k] = '0;
    failures        = 0;
    cells_sent      = 0;
    results_checked = 0;
    saturated_seen  = 0;
    settings_used   = 0;
    burst_left      = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table; change setting only once the block has drained.
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (i == 0 || directed_cells[i].setting != setting) begin
        if (i != 0) settle_block();
        setting = directed_cells[i].setting;
        apply_directed_setting(setting);
      end
      send_cell('{temperature: directed_cells[i].temperature,
                  first_of_frame: directed_cells[i].first_of_frame},
                directed_cells[i].known, directed_cells[i].want);
    end
    settle_block();

    phase_no = 0;
    while (cells_sent < DIRECTED_LEN + RANDOM_CELLS) begin
      run_random_phase(phase_no);
      phase_no++;
    end

    // settle_block has already waited out the pipeline; give stray results a chance
    repeat (2 * PIPE_SETTLE) @(posedge clk);

    $display("Covered %0d cells under %0d register settings, incl. 64-wide and 64-tall grids.",
             cells_sent, settings_used);
    $display("Checked %0d updated cells, %0d of them saturated.", results_checked,
             saturated_seen);
    if (failures == 0) begin
      $display("heat_diffusion_stencil_step regression: pass");
    end else begin
      $display("heat_diffusion_stencil_step regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hds_pkg.sv
rtl/hds_line_buf.sv
rtl/hds_window.sv
rtl/hds_update.sv
rtl/heat_diffusion_stencil_step.sv
verif/tb_heat_diffusion_stencil_step.sv
